// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

`endif

// ===== rtl/core/hcv_pkg.sv =====
// Shared types and constants of the hue-cycle HSV-to-RGB converter.
package hcv_pkg;

	localparam int Q8_W      = 9;
	localparam int CFG_IDX_W = 1;
	localparam int FOLD_W    = 17;
	localparam int C16_W     = 17;
	localparam int NUM_W     = 22;

	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

	localparam logic [Q8_W-1:0] Q8_ONE   = 9'd256;
	localparam logic [Q8_W-1:0] Q8_RESET = 9'd179;

	typedef struct packed {
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [31:0] time_ms;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} out_word_t;

	// Colour seed folded mod 360 up front, time stamp still raw.
	typedef struct packed {
		logic [FOLD_W-1:0] seed_fold;
		logic [31:0]       time_ms;
	} mid_word_t;

	// Terms derived from saturation and value, numerators over 65536*60.
	typedef struct packed {
		logic [C16_W-1:0] c16;
		logic [NUM_W-1:0] cn;
		logic [NUM_W-1:0] mn;
	} cfg_terms_t;

endpackage

// ===== rtl/core/hcv_fifo.sv =====
// Small register FIFO with push/full and pop/empty sides.
`include "assert_macros.svh"

module hcv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))

endmodule

// ===== rtl/core/hcv_front.sv =====
// Front end: accept colour words and fold the colour seed mod 360.
module hcv_front (
	input  logic               push,
	output logic               full,
	input  hcv_pkg::in_word_t  color,
	input  logic               mid_full,
	output logic               mid_push,
	output hcv_pkg::mid_word_t mid_word
);
	import hcv_pkg::*;

	// (r*255 + g)*255 + b is congruent to 225r + 255g + b mod 360.
	assign mid_word.seed_fold = FOLD_W'(color.red_in) * FOLD_W'(225)
		+ FOLD_W'(color.green_in) * FOLD_W'(255)
		+ FOLD_W'(color.blue_in);
	assign mid_word.time_ms = color.time_ms;
	assign mid_push         = push && !mid_full;
	assign full             = mid_full;

endmodule

// ===== rtl/core/hcv_cfg.sv =====
// Configuration registers and the chroma terms derived from them.
module hcv_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hcv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hcv_pkg::Q8_W-1:0]            cfg_data,
	output hcv_pkg::cfg_terms_t                 terms
);
	import hcv_pkg::*;

	logic [Q8_W-1:0]  sat_q;
	logic [Q8_W-1:0]  bri_q;
	logic [Q8_W-1:0]  sat_clamp;
	logic [Q8_W-1:0]  bri_clamp;
	logic [C16_W-1:0] c16_q;
	logic [C16_W-1:0] v16_q;
	cfg_terms_t       terms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= Q8_RESET;
			bri_q <= Q8_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SATURATION: sat_q <= cfg_data;
				REG_BRIGHTNESS: bri_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate anything above one.
	assign sat_clamp = (sat_q > Q8_ONE) ? Q8_ONE : sat_q;
	assign bri_clamp = (bri_q > Q8_ONE) ? Q8_ONE : bri_q;

	always_ff @(posedge clk) begin
		c16_q       <= C16_W'(sat_clamp) * C16_W'(bri_clamp);
		v16_q       <= {bri_clamp, 8'd0};
		terms_q.c16 <= c16_q;
		terms_q.cn  <= NUM_W'(c16_q) * NUM_W'(60);
		terms_q.mn  <= NUM_W'(v16_q - c16_q) * NUM_W'(60);
	end

	assign terms = terms_q;

endmodule

// ===== rtl/core/hcv_back.sv =====
// Back end: hue reduction and six-sector conversion pipeline with output credit.
`include "assert_macros.svh"

module hcv_back #(
	parameter int OUT_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hcv_pkg::cfg_terms_t terms,
	input  logic               mid_empty,
	input  hcv_pkg::mid_word_t mid_word,
	output logic               mid_pop,
	input  logic               out_pop_done,
	output logic               out_push,
	output hcv_pkg::out_word_t out_word
);
	import hcv_pkg::*;

	localparam int RES_W = $clog2(OUT_DEPTH + 1);

	localparam logic [31:0] TIME_RECIP = 32'hCCCC_CCCD; // t/10 = t*R >> 35
	localparam logic [27:0] HUE_RECIP  = 28'd190887436; // y/45 = y*R >> 33
	localparam logic [12:0] CHAN_RECIP = 13'd4370;      // z/15 = z*R >> 16

	typedef enum logic [2:0] {
		SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
	} sector_t;

	logic             issue;
	logic [RES_W-1:0] reserved_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [31:0]       t_s1;
	logic [FOLD_W-1:0] fold_s1;
	logic [63:0]       prod_s2;
	logic [FOLD_W-1:0] fold_s2;
	logic [29:0]       x_s3;
	logic [54:0]       pq_s4;
	logic [29:0]       x_s4;
	logic [29:0]       rem_full;
	logic [9:0]        rem10;
	logic [8:0]        hue_s5;
	logic [6:0]        h120_d;
	sector_t           sec_d;
	logic [5:0]        dist_d;
	sector_t           sec_s6;
	logic [5:0]        dist_s6;
	logic [NUM_W-1:0]  xn;
	logic [NUM_W-1:0]  num_d  [3];
	logic [NUM_W-1:0]  num_s7 [3];
	logic [11:0]       z_s8   [3];
	logic [7:0]        ch_s9  [3];

	// Take a word only when the output queue is sure to have room for it.
	assign issue   = !mid_empty && (reserved_q < RES_W'(OUT_DEPTH));
	assign mid_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			if (issue && !out_pop_done) begin
				reserved_q <= reserved_q + 1'b1;
			end else if (out_pop_done && !issue) begin
				reserved_q <= reserved_q - 1'b1;
			end
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{issue, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	assign rem_full = x_s4 - 30'(pq_s4[54:33]) * 30'(360);
	assign rem10    = rem_full[9:0];

	always_comb begin
		if (hue_s5 < 9'd60) begin
			sec_d  = SEC_RY;
			h120_d = 7'(hue_s5);
		end else if (hue_s5 < 9'd120) begin
			sec_d  = SEC_YG;
			h120_d = 7'(hue_s5);
		end else if (hue_s5 < 9'd180) begin
			sec_d  = SEC_GC;
			h120_d = 7'(hue_s5 - 9'd120);
		end else if (hue_s5 < 9'd240) begin
			sec_d  = SEC_CB;
			h120_d = 7'(hue_s5 - 9'd120);
		end else if (hue_s5 < 9'd300) begin
			sec_d  = SEC_BM;
			h120_d = 7'(hue_s5 - 9'd240);
		end else begin
			sec_d  = SEC_MR;
			h120_d = 7'(hue_s5 - 9'd240);
		end
		dist_d = (h120_d >= 7'd60) ? 6'(h120_d - 7'd60) : 6'(7'd60 - h120_d);
	end

	assign xn = NUM_W'(terms.c16) * NUM_W'(6'd60 - dist_s6);

	always_comb begin
		unique case (sec_s6)
			SEC_RY: begin
				num_d[0] = terms.cn; num_d[1] = xn;       num_d[2] = '0;
			end
			SEC_YG: begin
				num_d[0] = xn;       num_d[1] = terms.cn; num_d[2] = '0;
			end
			SEC_GC: begin
				num_d[0] = '0;       num_d[1] = terms.cn; num_d[2] = xn;
			end
			SEC_CB: begin
				num_d[0] = '0;       num_d[1] = xn;       num_d[2] = terms.cn;
			end
			SEC_BM: begin
				num_d[0] = xn;       num_d[1] = '0;       num_d[2] = terms.cn;
			end
			SEC_MR: begin
				num_d[0] = terms.cn; num_d[1] = '0;       num_d[2] = xn;
			end
			default: begin
				num_d[0] = '0;       num_d[1] = '0;       num_d[2] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		t_s1    <= mid_word.time_ms;
		fold_s1 <= mid_word.seed_fold;
		prod_s2 <= 64'(t_s1) * 64'(TIME_RECIP);
		fold_s2 <= fold_s1;
		x_s3    <= 30'(prod_s2[63:35]) + 30'(fold_s2);
		// x/360 = (x/8)/45
		pq_s4   <= 55'(x_s3[29:3]) * 55'(HUE_RECIP);
		x_s4    <= x_s3;
		hue_s5  <= (rem10 >= 10'd360) ? 9'(rem10 - 10'd360) : 9'(rem10);
		sec_s6  <= sec_d;
		dist_s6 <= dist_d;
		for (int i = 0; i < 3; i++) begin
			num_s7[i] <= num_d[i];
			// floor((n + m)*255 / 2^18) feeds the divide by 15
			z_s8[i]   <= 12'((30'(num_s7[i] + terms.mn) * 30'(255)) >> 18);
			ch_s9[i]  <= 8'((25'(z_s8[i]) * 25'(CHAN_RECIP)) >> 16);
		end
	end

	assign out_push           = v_s9;
	assign out_word.red_out   = ch_s9[0];
	assign out_word.green_out = ch_s9[1];
	assign out_word.blue_out  = ch_s9[2];

	`ASSERT_ALWAYS(a_reserved_bound, clk, arst_n, reserved_q <= RES_W'(OUT_DEPTH))
	`ASSERT_IMPLIES(a_push_has_credit, clk, arst_n, v_s9, reserved_q != '0)

endmodule

// ===== rtl/core/hue_cycle_hsv_to_rgb_top.sv =====
// Top level of the hue-cycle HSV-to-RGB converter.
//
// Input channel: drive color with push high; the word is taken at a rising
// edge where push is high and full is low. Each word is a colour seed plus a
// millisecond time stamp; hue = (seed + time/10) mod 360.
// Result channel: while empty is low, result holds the oldest converted
// colour; it is taken at a rising edge where pop is high and empty is low.
// Every input word yields exactly one result word, in order.
// Configuration: cfg_we writes cfg_data into saturation (index 0) or
// brightness (index 1), Q1.8 with 256 meaning one; write only while idle.
// Path: an accepted word passes through the 4-entry middle queue and then the
// 9-stage back pipeline into the output queue.
// Throughput: one word per cycle; the front takes a word every cycle while
// the middle queue has room, and the back issues one while its output credit
// (16 result slots) is not used up.
// Reset: arst_n clears both queues and the pipeline valids and loads 179
// (about 0.7) into both registers.
// Stall: when pop stays low the output queue fills, the back stops issuing,
// the middle queue fills and full rises; no word is lost.
`include "assert_macros.svh"

module hue_cycle_hsv_to_rgb_top #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  hcv_pkg::in_word_t             color,
	output logic                          empty,
	input  logic                          pop,
	output hcv_pkg::out_word_t            result,
	input  logic                          cfg_we,
	input  logic [hcv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcv_pkg::Q8_W-1:0]      cfg_data
);
	import hcv_pkg::*;

	logic       mid_push;
	logic       mid_full;
	logic       mid_empty;
	logic       mid_pop;
	mid_word_t  mid_wdata;
	mid_word_t  mid_rdata;
	cfg_terms_t terms;
	logic       out_push;
	logic       out_full;
	out_word_t  out_wdata;
	logic       out_pop_done;

	// Fold the colour seed and hand the word to the middle queue.
	hcv_front u_front (
		.push     (push),
		.full     (full),
		.color    (color),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_word (mid_wdata)
	);

	// Decouple acceptance from the conversion pipeline.
	hcv_fifo #(
		.WIDTH ($bits(mid_word_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// Hold saturation and value, precompute chroma and offset numerators.
	hcv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.terms     (terms)
	);

	// Advance words through hue reduction and channel conversion.
	hcv_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.terms        (terms),
		.mid_empty    (mid_empty),
		.mid_word     (mid_rdata),
		.mid_pop      (mid_pop),
		.out_pop_done (out_pop_done),
		.out_push     (out_push),
		.out_word     (out_wdata)
	);

	assign out_pop_done = pop && !empty;

	// Hold finished results until the receiver drains them.
	hcv_fifo #(
		.WIDTH ($bits(out_word_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	`ASSERT_IMPLIES(a_out_no_overflow, clk, arst_n, out_push, !out_full)

endmodule
